[hdl/lset_pkg.sv]
// Package for the local score excursion tracker.
// Holds the result kind codes, the result record and the per-request result bundle.
// No dependencies.
package lset_pkg;

  localparam int unsigned ValWidth = 31;
  localparam int unsigned PosWidth = 17;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntWidth = 3;
  localparam int unsigned IdxWidth = 2;
  localparam int unsigned OutDataWidth = 72;

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_GLOBAL  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [ValWidth-1:0]   seg_value;
    logic [PosWidth-1:0]   seg_begin;
    logic [PosWidth-1:0]   seg_end;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [CntWidth-1:0]      count;
  } bundle_t;

endpackage

[hdl/lset_core.sv]
// Lindley sum and excursion state, updated once per accepted score request.
// Builds the bundle of up to four results that the request causes.
// Depends on lset_pkg.
module lset_core import lset_pkg::*; #(
  parameter int unsigned SCORE_WIDTH = 16,
  parameter int unsigned MAX_LEN     = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [SCORE_WIDTH-1:0] score_i,
  input  logic                   final_item_i,
  output bundle_t                bundle_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam logic [ValWidth-1:0] SumMax = {ValWidth{1'b1}};

  logic [ValWidth-1:0] sum_q, sum_d;
  logic [ValWidth-1:0] peak_q, peak_d;
  logic [PosWidth-1:0] pstart_q, pstart_d;
  logic [PosWidth-1:0] pend_q, pend_d;
  logic [ValWidth-1:0] best_q, best_d;
  logic [PosWidth-1:0] bbeg_q, bbeg_d;
  logic [PosWidth-1:0] bend_q, bend_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic                found_q, found_d;

  logic [PW-1:0]       idx;
  logic [PosWidth-1:0] idx17;
  logic signed [32:0]  score_ext;
  logic signed [32:0]  sum_next;

  assign idx       = (pos_q < PW'(MAX_LEN)) ? pos_q + PW'(1) : PW'(MAX_LEN);
  assign score_ext = 33'($signed(score_i));
  assign sum_next  = $signed({2'b00, sum_q}) + score_ext;

  if (PW >= PosWidth) begin : g_wide_pos
    assign idx17 = idx[PosWidth-1:0];
  end else begin : g_narrow_pos
    assign idx17 = PosWidth'(idx);
  end

  always_comb begin
    bundle_t             b;
    logic [CntWidth-1:0] n;
    b        = '0;
    n        = '0;
    sum_d    = sum_q;
    peak_d   = peak_q;
    pstart_d = pstart_q;
    pend_d   = pend_q;
    best_d   = best_q;
    bbeg_d   = bbeg_q;
    bend_d   = bend_q;
    found_d  = found_q;
    pos_d    = idx;

    if (pos_q == '0) begin
      b.res[n[IdxWidth-1:0]].kind = KIND_RECORD;
      n = n + CntWidth'(1);
    end

    if (sum_next < 0) begin
      b.res[n[IdxWidth-1:0]].kind      = KIND_RECORD;
      b.res[n[IdxWidth-1:0]].seg_begin = idx17;
      n = n + CntWidth'(1);
      sum_d = '0;
    end else if (sum_next == 0) begin
      sum_d = '0;
    end else begin
      if (sum_q == '0) begin
        if (peak_q != '0) begin
          b.res[n[IdxWidth-1:0]] = '{KIND_SEGMENT, peak_q, pstart_q, pend_q};
          n = n + CntWidth'(1);
          found_d = 1'b1;
          if (peak_q > best_q) begin
            best_d = peak_q;
            bbeg_d = pstart_q;
            bend_d = pend_q;
          end
          peak_d = '0;
          pend_d = '0;
        end
        pstart_d = idx17;
      end
      sum_d = (sum_next > $signed({2'b00, SumMax})) ? SumMax : sum_next[ValWidth-1:0];
      if (sum_d > peak_d) begin
        peak_d = sum_d;
        pend_d = idx17;
      end
    end

    if (final_item_i) begin
      if (peak_d != '0) begin
        b.res[n[IdxWidth-1:0]] = '{KIND_SEGMENT, peak_d, pstart_d, pend_d};
        n = n + CntWidth'(1);
        found_d = 1'b1;
        if (peak_d > best_d) begin
          best_d = peak_d;
          bbeg_d = pstart_d;
          bend_d = pend_d;
        end
      end
      if (!found_d) begin
        b.res[n[IdxWidth-1:0]].kind = KIND_SEGMENT;
        n = n + CntWidth'(1);
      end
      b.res[n[IdxWidth-1:0]] = '{KIND_GLOBAL, best_d, bbeg_d, bend_d};
      n = n + CntWidth'(1);
      sum_d    = '0;
      peak_d   = '0;
      pstart_d = '0;
      pend_d   = '0;
      best_d   = '0;
      bbeg_d   = '0;
      bend_d   = '0;
      pos_d    = '0;
      found_d  = 1'b0;
    end

    b.count  = n;
    bundle_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      peak_q   <= '0;
      pstart_q <= '0;
      pend_q   <= '0;
      best_q   <= '0;
      bbeg_q   <= '0;
      bend_q   <= '0;
      pos_q    <= '0;
      found_q  <= 1'b0;
    end else if (accept_i) begin
      sum_q    <= sum_d;
      peak_q   <= peak_d;
      pstart_q <= pstart_d;
      pend_q   <= pend_d;
      best_q   <= best_d;
      bbeg_q   <= bbeg_d;
      bend_q   <= bend_d;
      pos_q    <= pos_d;
      found_q  <= found_d;
    end
  end

endmodule

[hdl/lset_out.sv]
// Result register for one request's bundle; one result out per cycle while ready_i.
// Depends on lset_pkg.
module lset_out import lset_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  bundle_t bundle_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o,
  output logic    last_o
);

  bundle_t             bundle_q;
  logic                valid_q;
  logic [IdxWidth-1:0] idx_q;
  logic                last;
  logic                finishing;

  assign last      = {1'b0, idx_q} == (bundle_q.count - CntWidth'(1));
  assign finishing = valid_q && ready_i && last;
  assign free_o    = !valid_q || finishing;
  assign valid_o   = valid_q;
  assign result_o  = bundle_q.res[idx_q];
  assign last_o    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (accept_i && bundle_i.count != '0) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (finishing) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (valid_q && ready_i) begin
      idx_q <= idx_q + IdxWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && bundle_i.count != '0) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

[hdl/local_score_excursion_tracker_top.sv]
// Top level of the local score excursion tracker: score stream in, result stream out.
// Depends on lset_pkg, lset_core and lset_out.
//
//   Channel  Direction  tdata                          tuser  tlast
//   s_axis   in         score                          -      final_item
//   m_axis   out        seg_value, seg_begin, seg_end  kind   last_result
//
// A score request is taken when the single result register is free; its results leave
// that register one per cycle while m_axis_tready is high, so a request that causes
// results holds further input until its last result is taken.
// Requests that cause no result pass at one per cycle when that register is free.
// Reset clears all sums and positions and marks the result register empty at once.
// A stalled output holds the current result and blocks further input requests.
module local_score_excursion_tracker_top import lset_pkg::*; #(
  parameter int unsigned SCORE_WIDTH = 16,
  parameter int unsigned MAX_LEN     = 65536
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // score (bits SCORE_WIDTH-1:0), zero padding above
  input  logic [((SCORE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic                               s_axis_tlast,
  // seg_value [30:0], seg_begin [47:31], seg_end [64:48], zero padding above
  output logic [OutDataWidth-1:0]            m_axis_tdata,
  // kind [1:0]
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic                               m_axis_tlast
);

  logic    accept;
  logic    free;
  bundle_t bundle;
  result_t result;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  lset_core #(
    .SCORE_WIDTH(SCORE_WIDTH),
    .MAX_LEN    (MAX_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .score_i     (s_axis_tdata[SCORE_WIDTH-1:0]),
    .final_item_i(s_axis_tlast),
    .bundle_o    (bundle)
  );

  lset_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .bundle_i(bundle),
    .free_o  (free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .result_o(result),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataWidth'({result.seg_end, result.seg_begin, result.seg_value});
  assign m_axis_tuser = result.kind;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for local_score_excursion_tracker_top.
// Drives score requests, predicts record times, segments and the global local score,
// and checks every result; depends on lset_pkg and the RTL under hdl.
module tb_top;
  import lset_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen = 65536;
  localparam longint SumCap = 64'h7FFF_FFFF;
  localparam int CycleLimit = 1_000_000;
  localparam int DirRows = 25;
  localparam int TypedRows = 11;
  localparam int LongRun = 20;

  typedef struct {
    result_t res;
    logic    last;
  } result_exp_t;

  typedef struct {
    logic [15:0] score;
    logic        fin;
  } stim_row_t;

  typedef struct {
    int            row;
    kind_e         kind;
    logic [30:0]   seg_value;
    logic [16:0]   seg_begin;
    logic [16:0]   seg_end;
    logic          last;
  } typed_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tlast = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tlast;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_hold = 1'b0;
  bit          hold_go = 1'b0;
  int          mismatch_cnt = 0;
  int          result_cnt = 0;
  int          cycle_cnt = 0;

  result_exp_t pending_results[$];
  result_exp_t score_res[MaxResults];
  int          score_res_cnt;

  // Tracker state.
  logic [30:0] lsum = '0;
  logic [30:0] pk_val = '0;
  logic [16:0] pk_start = '0;
  logic [16:0] pk_end = '0;
  logic [30:0] best_val = '0;
  logic [16:0] best_begin = '0;
  logic [16:0] best_end = '0;
  logic [16:0] pos = '0;
  bit          seg_seen = 1'b0;

  stim_row_t dir_tab[DirRows] = '{
    '{16'd0, 1'b1}, '{16'd32767, 1'b1}, '{16'h8000, 1'b1},
    '{16'd5, 1'b0}, '{-16'sd5, 1'b0}, '{16'd3, 1'b0}, '{-16'sd100, 1'b0},
    '{16'd10, 1'b0}, '{16'd2, 1'b0}, '{-16'sd4, 1'b0}, '{16'd20, 1'b0},
    '{16'h8000, 1'b0}, '{16'd32767, 1'b0}, '{16'd1, 1'b1},
    '{-16'sd1, 1'b0}, '{16'd7, 1'b0}, '{-16'sd10, 1'b0}, '{16'd7, 1'b0},
    '{16'd0, 1'b1},
    '{16'd100, 1'b0}, '{-16'sd50, 1'b0}, '{16'd0, 1'b0}, '{16'd50, 1'b1},
    '{16'h5555, 1'b0}, '{16'hAAAA, 1'b1}
  };

  typed_exp_t typed_tab[TypedRows] = '{
    '{0, KIND_RECORD, 31'd0, 17'd0, 17'd0, 1'b0},
    '{0, KIND_SEGMENT, 31'd0, 17'd0, 17'd0, 1'b0},
    '{0, KIND_GLOBAL, 31'd0, 17'd0, 17'd0, 1'b1},
    '{1, KIND_RECORD, 31'd0, 17'd0, 17'd0, 1'b0},
    '{1, KIND_SEGMENT, 31'd32767, 17'd1, 17'd1, 1'b0},
    '{1, KIND_GLOBAL, 31'd32767, 17'd1, 17'd1, 1'b1},
    '{2, KIND_RECORD, 31'd0, 17'd0, 17'd0, 1'b0},
    '{2, KIND_RECORD, 31'd0, 17'd1, 17'd0, 1'b0},
    '{2, KIND_SEGMENT, 31'd0, 17'd0, 17'd0, 1'b0},
    '{2, KIND_GLOBAL, 31'd0, 17'd0, 17'd0, 1'b1},
    '{3, KIND_RECORD, 31'd0, 17'd0, 17'd0, 1'b1}
  };

  local_score_excursion_tracker_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tlast,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tlast
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void add_result(kind_e kind, logic [30:0] value, logic [16:0] seg_b,
                                     logic [16:0] seg_e);
    score_res[score_res_cnt].res.kind = kind;
    score_res[score_res_cnt].res.seg_value = value;
    score_res[score_res_cnt].res.seg_begin = seg_b;
    score_res[score_res_cnt].res.seg_end = seg_e;
    score_res[score_res_cnt].last = 1'b0;
    score_res_cnt++;
  endfunction

  function automatic void close_excursion();
    add_result(KIND_SEGMENT, pk_val, pk_start, pk_end);
    seg_seen = 1'b1;
    if (pk_val > best_val) begin
      best_val = pk_val;
      best_begin = pk_start;
      best_end = pk_end;
    end
  endfunction

  function automatic void track_score(logic [15:0] score, logic fin);
    longint nxt;
    logic [16:0] idx;
    score_res_cnt = 0;
    if (pos == 0) add_result(KIND_RECORD, '0, '0, '0);
    idx = (pos < MaxLen) ? pos + 17'd1 : 17'(MaxLen);
    pos = idx;
    nxt = longint'(lsum) + longint'($signed(score));
    if (nxt < 0) begin
      add_result(KIND_RECORD, '0, idx, '0);
      lsum = '0;
    end else if (nxt == 0) begin
      lsum = '0;
    end else begin
      if (lsum == 0) begin
        if (pk_val != 0) begin
          close_excursion();
          pk_val = '0;
          pk_end = '0;
        end
        pk_start = idx;
      end
      lsum = (nxt > SumCap) ? SumCap[30:0] : nxt[30:0];
      if (lsum > pk_val) begin
        pk_val = lsum;
        pk_end = idx;
      end
    end
    if (fin) begin
      if (pk_val != 0) close_excursion();
      if (!seg_seen) add_result(KIND_SEGMENT, '0, '0, '0);
      add_result(KIND_GLOBAL, best_val, best_begin, best_end);
      lsum = '0;
      pk_val = '0;
      pk_start = '0;
      pk_end = '0;
      best_val = '0;
      best_begin = '0;
      best_end = '0;
      pos = '0;
      seg_seen = 1'b0;
    end
    if (score_res_cnt > 0) score_res[score_res_cnt-1].last = 1'b1;
  endfunction

  function automatic logic [15:0] pick_score(int drift);
    int v;
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: begin
        v = int'($urandom_range(60)) - 30 + drift;
        return v[15:0];
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_cnt < 100) begin
      $display("mismatch at result %0d: %s got %0d, want %0d", result_cnt, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // Sends one score request; row selects typed-in expectations of the directed table.
  task automatic send_score(logic [15:0] score, logic fin, int row);
    bit typed;
    result_exp_t e;
    s_axis_tdata <= score;
    s_axis_tlast <= fin;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    track_score(score, fin);
    typed = 1'b0;
    foreach (typed_tab[k]) begin
      if (typed_tab[k].row == row) begin
        e.res.kind = typed_tab[k].kind;
        e.res.seg_value = typed_tab[k].seg_value;
        e.res.seg_begin = typed_tab[k].seg_begin;
        e.res.seg_end = typed_tab[k].seg_end;
        e.last = typed_tab[k].last;
        pending_results.insert(pending_results.size(), e);
        typed = 1'b1;
      end
    end
    if (!typed) begin
      for (int k = 0; k < score_res_cnt; k++) begin
        pending_results.insert(pending_results.size(), score_res[k]);
      end
    end
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Mostly whole sequences with random content, some cut short by an early final flag.
  task automatic send_random(int n_items);
    int left;
    int len;
    int drift;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(60, 30) : $urandom_range(16, 1);
      drift = int'($urandom_range(20)) - 8;
      for (int i = 0; i < len && left > 0; i++) begin
        send_score(pick_score(drift), (i == len - 1) || (left == 1) || ($urandom_range(19) == 0),
                   -1);
        left--;
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : check_results
    result_exp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", m_axis_tuser, -1);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.res.kind) report_mismatch("kind", m_axis_tuser, want.res.kind);
        if (m_axis_tdata[30:0] !== want.res.seg_value) begin
          report_mismatch("seg_value", m_axis_tdata[30:0], want.res.seg_value);
        end
        if (m_axis_tdata[47:31] !== want.res.seg_begin) begin
          report_mismatch("seg_begin", m_axis_tdata[47:31], want.res.seg_begin);
        end
        if (m_axis_tdata[64:48] !== want.res.seg_end) begin
          report_mismatch("seg_end", m_axis_tdata[64:48], want.res.seg_end);
        end
        if (m_axis_tlast !== want.last) report_mismatch("last_result", m_axis_tlast, want.last);
      end
      result_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[local_score_excursion_tracker_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 23;
    rx_idle_pct = 87;
    hold_go = 1'b1;
    for (int r = 0; r < DirRows; r++) send_score(dir_tab[r].score, dir_tab[r].fin, r);
    send_random(130);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    tx_idle_pct = 87;
    rx_idle_pct = 23;
    send_random(130);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(105);
    // One sequence of top scores builds a long excursion with a large sum.
    for (int k = 0; k < LongRun; k++) send_score(16'h7FFF, k == LongRun - 1, -1);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[local_score_excursion_tracker_top] OK");
    end else begin
      $display("[local_score_excursion_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
